/* sv/ogg_page_deframer_defines.svh */
// assertion macros shared by the deframer modules
`ifndef OGG_PAGE_DEFRAMER_DEFINES_SVH
`define OGG_PAGE_DEFRAMER_DEFINES_SVH

// checked at every clock edge outside reset
`define OPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every clock edge, reset included
`define OPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ogg_pd_pkg.sv */
`timescale 1ns / 1ps
package ogg_pd_pkg;

  localparam int SegMax = 255;

  localparam logic [4:0] HDR_LAST = 5'd26;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAGE    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_STOP    = 2'd3;

  typedef struct packed {
    logic [7:0] lacing;
    logic [7:0] zeros;
  } seg_entry_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    seg_entry_t data;
  } seg_wr_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload_byte;
    logic [7:0]         packets_closed;
    logic [7:0]         page_flags;
    logic signed [63:0] granule_position;
    logic [31:0]        stream_serial;
    logic [31:0]        page_sequence;
  } result_t;

  // "OggS"
  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0: val = 8'h4F;
      2'd1: val = 8'h67;
      2'd2: val = 8'h67;
      default: val = 8'h53;
    endcase
    return val;
  endfunction

endpackage

/* sv/ogg_pd_seg_mem.sv */
`timescale 1ns / 1ps
module ogg_pd_seg_mem (
  input  logic                   clk,
  input  ogg_pd_pkg::seg_wr_t    wr,
  input  logic [7:0]             raddr,
  output ogg_pd_pkg::seg_entry_t rdata
);
  import ogg_pd_pkg::*;

  seg_entry_t mem [0:SegMax-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // write-through so a same-cycle write is seen by the read
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ogg_pd_parser.sv */
`timescale 1ns / 1ps
`include "ogg_page_deframer_defines.svh"
module ogg_pd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output ogg_pd_pkg::result_t res
);
  import ogg_pd_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TABLE  = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [4:0]  hpos, hpos_next;
  logic        mismatch, mismatch_next;
  logic [7:0]  flags, flags_next;
  logic [63:0] granule, granule_next;
  logic [31:0] serial, serial_next;
  logic [31:0] sequence_num, sequence_num_next;
  logic [7:0]  seg_total, seg_total_next;
  logic [7:0]  leading_zeros, leading_zeros_next;
  logic        nz_valid, nz_valid_next;
  logic [7:0]  last_idx, last_idx_next;
  logic [7:0]  cursor, cursor_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  zrun, zrun_next;
  logic [7:0]  lac_last, lac_last_next;
  seg_entry_t  head, head_next;
  seg_entry_t  cur, cur_next;

  seg_wr_t     wr;
  seg_wr_t     wr_req;
  seg_entry_t  rdata;
  logic [7:0]  rd_base;
  logic [7:0]  raddr;
  logic [7:0]  slot;
  logic [2:0]  gran_lane;
  logic [1:0]  serial_lane;
  logic [1:0]  seq_lane;

  assign gran_lane   = 3'(hpos - 5'd6);
  assign serial_lane = 2'(hpos - 5'd14);
  assign seq_lane    = 2'(hpos - 5'd18);
  assign slot        = nz_valid ? last_idx + 8'd1 : 8'd0;

  always_comb begin
    phase_next         = phase;
    hpos_next          = hpos;
    mismatch_next      = mismatch;
    flags_next         = flags;
    granule_next       = granule;
    serial_next        = serial;
    sequence_num_next  = sequence_num;
    seg_total_next     = seg_total;
    leading_zeros_next = leading_zeros;
    nz_valid_next      = nz_valid;
    last_idx_next      = last_idx;
    cursor_next        = cursor;
    bytes_left_next    = bytes_left;
    zrun_next          = zrun;
    lac_last_next      = lac_last;
    cur_next           = cur;
    wr_req             = '0;
    res.kind           = KIND_HEADER;
    res.payload_byte   = 8'd0;
    res.packets_closed = 8'd0;

    unique case (phase)
      PH_HEADER: begin
        if (hpos == 5'd0) begin
          mismatch_next      = 1'b0;
          flags_next         = 8'd0;
          granule_next       = 64'd0;
          serial_next        = 32'd0;
          sequence_num_next  = 32'd0;
          leading_zeros_next = 8'd0;
          nz_valid_next      = 1'b0;
          last_idx_next      = 8'd0;
        end
        if (hpos < 5'd4) begin
          if (in_byte != capture_byte(hpos[1:0])) mismatch_next = 1'b1;
        end else if (hpos == 5'd4) begin
          if (in_byte != 8'd0) mismatch_next = 1'b1;
        end else if (hpos == 5'd5) begin
          flags_next = in_byte;
        end else if (hpos < 5'd14) begin
          granule_next[{gran_lane, 3'b000} +: 8] = in_byte;
        end else if (hpos < 5'd18) begin
          serial_next[{serial_lane, 3'b000} +: 8] = in_byte;
        end else if (hpos < 5'd22) begin
          sequence_num_next[{seq_lane, 3'b000} +: 8] = in_byte;
        end
        if (hpos >= HDR_LAST) begin
          hpos_next = 5'd0;
          if (mismatch_next) begin
            phase_next = PH_STOP;
            res.kind   = KIND_STOP;
          end else begin
            seg_total_next = in_byte;
            cursor_next    = 8'd0;
            phase_next     = (in_byte == 8'd0) ? PH_HEADER : PH_TABLE;
            res.kind       = KIND_PAGE;
          end
        end else begin
          hpos_next = hpos + 5'd1;
        end
      end
      PH_TABLE: begin
        if (in_byte == 8'd0) begin
          if (nz_valid) begin
            // bump the zero run that trails the latest nonzero segment
            zrun_next   = zrun + 8'd1;
            wr_req.en   = 1'b1;
            wr_req.addr = last_idx;
            wr_req.data = '{lacing: lac_last, zeros: zrun + 8'd1};
          end else begin
            leading_zeros_next = leading_zeros + 8'd1;
          end
        end else begin
          wr_req.en     = 1'b1;
          wr_req.addr   = slot;
          wr_req.data   = '{lacing: in_byte, zeros: 8'd0};
          last_idx_next = slot;
          lac_last_next = in_byte;
          zrun_next     = 8'd0;
          nz_valid_next = 1'b1;
        end
        cursor_next = cursor + 8'd1;
        if (cursor_next == seg_total) begin
          res.packets_closed = leading_zeros_next;
          if (nz_valid_next) begin
            phase_next      = PH_BODY;
            cursor_next     = 8'd0;
            cur_next        = (wr_req.en && (wr_req.addr == 8'd0)) ? wr_req.data : head;
            bytes_left_next = cur_next.lacing;
          end else begin
            phase_next = PH_HEADER;
            hpos_next  = 5'd0;
          end
        end
      end
      PH_BODY: begin
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = in_byte;
        if (bytes_left > 8'd1) begin
          bytes_left_next = bytes_left - 8'd1;
        end else begin
          bytes_left_next    = 8'd0;
          res.packets_closed = {7'd0, cur.lacing != 8'hFF} + cur.zeros;
          if (cursor >= last_idx) begin
            phase_next = PH_HEADER;
            hpos_next  = 5'd0;
          end else begin
            // rdata already holds the entry after the cursor
            cursor_next     = cursor + 8'd1;
            cur_next        = rdata;
            bytes_left_next = rdata.lacing;
          end
        end
      end
      default: begin
        res.kind = KIND_STOP;
      end
    endcase

    res.page_flags       = flags_next;
    res.granule_position = granule_next;
    res.stream_serial    = serial_next;
    res.page_sequence    = sequence_num_next;
  end

  // shadow of entry zero, so the body can start without a memory read
  assign head_next = (wr_req.en && (wr_req.addr == 8'd0)) ? wr_req.data : head;

  assign wr.en   = wr_req.en && step;
  assign wr.addr = wr_req.addr;
  assign wr.data = wr_req.data;

  assign rd_base = step ? cursor_next : cursor;
  assign raddr   = (rd_base >= 8'(SegMax - 1)) ? 8'(SegMax - 1) : rd_base + 8'd1;

  ogg_pd_seg_mem u_seg_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hpos          <= 5'd0;
      mismatch      <= 1'b0;
      flags         <= 8'd0;
      granule       <= 64'd0;
      serial        <= 32'd0;
      sequence_num  <= 32'd0;
      seg_total     <= 8'd0;
      leading_zeros <= 8'd0;
      nz_valid      <= 1'b0;
      last_idx      <= 8'd0;
      cursor        <= 8'd0;
      bytes_left    <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      hpos          <= hpos_next;
      mismatch      <= mismatch_next;
      flags         <= flags_next;
      granule       <= granule_next;
      serial        <= serial_next;
      sequence_num  <= sequence_num_next;
      seg_total     <= seg_total_next;
      leading_zeros <= leading_zeros_next;
      nz_valid      <= nz_valid_next;
      last_idx      <= last_idx_next;
      cursor        <= cursor_next;
      bytes_left    <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      zrun     <= zrun_next;
      lac_last <= lac_last_next;
      head     <= head_next;
      cur      <= cur_next;
    end
  end

  `OPD_ASSERT_ALWAYS(a_reset_to_header, clk, rst |=> phase == PH_HEADER, "phase not header after reset")
  `OPD_ASSERT(a_stop_sticky, clk, rst, phase == PH_STOP |=> phase == PH_STOP, "left stop phase")
  `OPD_ASSERT(a_body_cursor, clk, rst, phase == PH_BODY |-> cursor <= last_idx, "cursor past last segment")
  `OPD_ASSERT(a_body_count, clk, rst, phase == PH_BODY |-> bytes_left != 8'd0, "empty segment in body")

endmodule

/* sv/ogg_page_deframer.sv */
// Ogg page deframer: parses an Ogg stream one byte per item.
// Input channel: stream_valid / stream_stall carrying stream_byte.
// Result channel: result_valid / result_stall carrying kind, payload_byte,
// packets_closed and the held page header fields (page_flags,
// granule_position, stream_serial, page_sequence).
// Every input byte yields exactly one result item.
// A byte accepted into the input register is parsed from there into the
// result register, from which its result is shown.
// Throughput: one byte per cycle while result_stall is low; the parse state
// and the segment table memory (one write port, one registered read port)
// update only when a byte steps through. The body path prefetches the next
// segment entry so short segments run back to back.
// While result_stall is high the result register holds and one more byte
// can wait in the input register; after that stream_stall rises.
// Reset (rst, synchronous) empties both registers and returns the parser
// to the start of a page header; the segment table needs no clearing.
// A bad capture pattern or version stops the parser until reset.
`timescale 1ns / 1ps
`include "ogg_page_deframer_defines.svh"
module ogg_page_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               stream_valid,
  output logic               stream_stall,
  input  logic [7:0]         stream_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [7:0]         payload_byte,
  output logic [7:0]         packets_closed,
  output logic [7:0]         page_flags,
  output logic signed [63:0] granule_position,
  output logic [31:0]        stream_serial,
  output logic [31:0]        page_sequence
);
  import ogg_pd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  logic       accept;
  result_t    res;
  result_t    res_r;

  assign advance      = !result_valid || !result_stall;
  assign step         = in_full && advance;
  assign stream_stall = in_full && !advance;
  assign accept       = stream_valid && !stream_stall;

  ogg_pd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= stream_byte;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign kind             = res_r.kind;
  assign payload_byte     = res_r.payload_byte;
  assign packets_closed   = res_r.packets_closed;
  assign page_flags       = res_r.page_flags;
  assign granule_position = res_r.granule_position;
  assign stream_serial    = res_r.stream_serial;
  assign page_sequence    = res_r.page_sequence;

  `OPD_ASSERT(a_payload_zero, clk, rst, result_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0, "payload outside body")
  `OPD_ASSERT(a_stop_result, clk, rst, result_valid && kind == KIND_STOP |=> !result_valid || kind == KIND_STOP, "result after stop")
  `OPD_ASSERT(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(res_r), "result changed while stalled")

endmodule

/* sim/tb_ogg_page_deframer.sv */
`timescale 1ns / 1ps
module tb_ogg_page_deframer;
  import ogg_pd_pkg::*;

  localparam int ITEM_GOAL = 1510;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [31:0] OGG_MAGIC = "OggS";

  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_TABLE,
    PARSE_BODY,
    PARSE_STOP
  } parse_phase_e;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    logic [1:0] kind;
    logic [7:0] closed;
  } plan_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               stream_valid = 1'b0;
  logic               stream_stall;
  logic [7:0]         stream_byte = 8'h00;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic [7:0]         packets_closed;
  logic [7:0]         page_flags;
  logic signed [63:0] granule_position;
  logic [31:0]        stream_serial;
  logic [31:0]        page_sequence;

  ogg_page_deframer u_dut (
    .clk              (clk),
    .rst              (rst),
    .stream_valid     (stream_valid),
    .stream_stall     (stream_stall),
    .stream_byte      (stream_byte),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .kind             (kind),
    .payload_byte     (payload_byte),
    .packets_closed   (packets_closed),
    .page_flags       (page_flags),
    .granule_position (granule_position),
    .stream_serial    (stream_serial),
    .page_sequence    (page_sequence)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  plan_row_t stream_plan[$];
  result_t   pending_results[$];
  int        plan_idx = 0;
  int        quiet_cycles = 0;
  int        mismatches = 0;

  int unsigned send_idle_pct[4] = '{0, 55, 0, 22};
  int unsigned recv_stall_pct[4] = '{0, 0, 55, 22};

  // page parser state
  parse_phase_e parse_phase;
  logic [4:0]   hdr_pos;
  logic         hdr_bad;
  logic [7:0]   flags_q;
  logic [63:0]  granule_q;
  logic [31:0]  serial_q;
  logic [31:0]  sequence_q;
  logic [7:0]   seg_count;
  logic [7:0]   lace_mem[255];
  logic [7:0]   zero_run[255];
  logic [7:0]   lead_zeros;
  logic         nz_seen;
  logic [7:0]   last_nz;
  logic [7:0]   seg_cur;
  logic [7:0]   body_left;

  task automatic parser_clear();
    parse_phase = PARSE_HEADER;
    hdr_pos = '0;
    hdr_bad = 1'b0;
    flags_q = '0;
    granule_q = '0;
    serial_q = '0;
    sequence_q = '0;
    seg_count = '0;
    lead_zeros = '0;
    nz_seen = 1'b0;
    last_nz = '0;
    seg_cur = '0;
    body_left = '0;
  endtask

  task automatic parse_stream_byte(input logic [7:0] b, output result_t r);
    int p;
    logic [7:0] slot;
    r = '0;
    p = hdr_pos;
    case (parse_phase)
      PARSE_HEADER: begin
        if (p == 0) begin
          hdr_bad = 1'b0;
          flags_q = '0;
          granule_q = '0;
          serial_q = '0;
          sequence_q = '0;
          lead_zeros = '0;
          nz_seen = 1'b0;
          last_nz = '0;
        end
        if (p < 4) begin
          if (b != OGG_MAGIC[31 - 8 * p -: 8]) hdr_bad = 1'b1;
        end else if (p == 4) begin
          if (b != 8'h00) hdr_bad = 1'b1;
        end else if (p == 5) begin
          flags_q = b;
        end else if (p < 14) begin
          granule_q[8 * (p - 6) +: 8] = b;
        end else if (p < 18) begin
          serial_q[8 * (p - 14) +: 8] = b;
        end else if (p < 22) begin
          sequence_q[8 * (p - 18) +: 8] = b;
        end
        if (hdr_pos == HDR_LAST) begin
          hdr_pos = '0;
          if (hdr_bad) begin
            parse_phase = PARSE_STOP;
            r.kind = KIND_STOP;
          end else begin
            seg_count = b;
            seg_cur = '0;
            parse_phase = (b == 8'h00) ? PARSE_HEADER : PARSE_TABLE;
            r.kind = KIND_PAGE;
          end
        end else begin
          hdr_pos = hdr_pos + 5'd1;
        end
      end
      PARSE_TABLE: begin
        if (b == 8'h00) begin
          if (nz_seen) zero_run[last_nz] = zero_run[last_nz] + 8'd1;
          else lead_zeros = lead_zeros + 8'd1;
        end else begin
          slot = nz_seen ? last_nz + 8'd1 : 8'd0;
          lace_mem[slot] = b;
          zero_run[slot] = '0;
          last_nz = slot;
          nz_seen = 1'b1;
        end
        seg_cur = seg_cur + 8'd1;
        if (seg_cur == seg_count) begin
          // zeros ahead of the first real segment all close here
          r.packets_closed = lead_zeros;
          if (nz_seen) begin
            parse_phase = PARSE_BODY;
            seg_cur = '0;
            body_left = lace_mem[0];
          end else begin
            parse_phase = PARSE_HEADER;
            hdr_pos = '0;
          end
        end
      end
      PARSE_BODY: begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        if (body_left > 8'd1) begin
          body_left = body_left - 8'd1;
        end else begin
          body_left = '0;
          r.packets_closed = 8'((lace_mem[seg_cur] != 8'd255) + zero_run[seg_cur]);
          if (seg_cur >= last_nz) begin
            parse_phase = PARSE_HEADER;
            hdr_pos = '0;
          end else begin
            seg_cur = seg_cur + 8'd1;
            body_left = lace_mem[seg_cur];
          end
        end
      end
      default: r.kind = KIND_STOP;
    endcase
    r.page_flags = flags_q;
    r.granule_position = granule_q;
    r.stream_serial = serial_q;
    r.page_sequence = sequence_q;
  endtask

  task automatic check_field(input string label, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h got %0h", $time, label, want_v, got_v);
    end
  endtask

  task automatic push_row(input logic [7:0] b, input bit typed, input logic [1:0] k,
                          input logic [7:0] closed);
    plan_row_t row;
    row.b = b;
    row.typed = typed;
    row.kind = k;
    row.closed = closed;
    stream_plan = {stream_plan, row};
  endtask

  task automatic push_header(input logic [7:0] flags, input logic [63:0] granule,
                             input logic [31:0] serial, input logic [31:0] seq,
                             input logic [7:0] nseg, input bit typed);
    logic [7:0] hdr[27];
    for (int i = 0; i < 4; i++) hdr[i] = OGG_MAGIC[31 - 8 * i -: 8];
    hdr[4] = 8'h00;
    hdr[5] = flags;
    for (int i = 0; i < 8; i++) hdr[6 + i] = granule[8 * i +: 8];
    for (int i = 0; i < 4; i++) begin
      hdr[14 + i] = serial[8 * i +: 8];
      hdr[18 + i] = seq[8 * i +: 8];
      hdr[22 + i] = 8'($urandom_range(255));
    end
    hdr[26] = nseg;
    for (int i = 0; i < 27; i++)
      push_row(hdr[i], typed, (i == 26) ? KIND_PAGE : KIND_HEADER, 8'd0);
  endtask

  function automatic logic [7:0] pick_lacing(input bit tiny);
    int r;
    r = $urandom_range(99);
    if (tiny) return 8'($urandom_range(2));
    if (r < 30) return 8'd0;
    if (r < 35) return 8'd255;
    if (r < 88) return 8'($urandom_range(6, 1));
    return 8'($urandom_range(40, 7));
  endfunction

  task automatic add_random_page(input bit big);
    int nseg;
    int mode;
    bit zeros_only;
    logic [7:0] lace[$];
    mode = $urandom_range(99);
    zeros_only = ($urandom_range(9) == 0);
    if (big) nseg = 255;
    else if (mode < 8) nseg = 0;
    else if (mode < 10) nseg = $urandom_range(255, 200);
    else if (mode < 70) nseg = $urandom_range(6, 1);
    else nseg = $urandom_range(24, 7);
    push_header(8'($urandom), {$urandom, $urandom}, $urandom, $urandom, 8'(nseg), 1'b0);
    for (int i = 0; i < nseg; i++) begin
      lace = {lace, (zeros_only ? 8'd0 : pick_lacing(big || nseg > 24))};
      push_row(lace[i], 1'b0, KIND_HEADER, 8'd0);
    end
    foreach (lace[i])
      for (int j = 0; j < lace[i]; j++)
        push_row(8'($urandom_range(255)), 1'b0, KIND_HEADER, 8'd0);
  endtask

  always @(posedge clk) begin
    result_t want;
    plan_row_t row;
    int ph;
    if (rst) begin
      stream_valid <= 1'b0;
      result_stall <= 1'b0;
      plan_idx = 0;
      quiet_cycles = 0;
      parser_clear();
    end else begin
      quiet_cycles++;
      if (result_valid && !result_stall) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none got kind %0d payload %0h closed %0d",
                   $time, kind, payload_byte, packets_closed);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("packets_closed", want.packets_closed, packets_closed);
          check_field("page_flags", want.page_flags, page_flags);
          check_field("granule_position", want.granule_position, granule_position);
          check_field("stream_serial", want.stream_serial, stream_serial);
          check_field("page_sequence", want.page_sequence, page_sequence);
        end
      end
      if (stream_valid && !stream_stall) begin
        quiet_cycles = 0;
        row = stream_plan[plan_idx];
        parse_stream_byte(row.b, want);
        if (row.typed) begin
          want.kind = row.kind;
          want.payload_byte = (row.kind == KIND_PAYLOAD) ? row.b : 8'h00;
          want.packets_closed = row.closed;
        end
        pending_results = {pending_results, want};
        plan_idx++;
      end
      ph = (plan_idx * 4) / stream_plan.size();
      if (ph > 3) ph = 3;
      if (!stream_valid || !stream_stall) begin
        if (plan_idx < stream_plan.size() && $urandom_range(99) >= send_idle_pct[ph]) begin
          stream_valid <= 1'b1;
          stream_byte <= stream_plan[plan_idx].b;
        end else begin
          stream_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct[ph]);
    end
  end

  initial begin
    bit timed_out;
    int bad_pos;
    timed_out = 1'b0;

    // empty table, every header field at its all-ones extreme
    push_header(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b1);
    // no body at all: each zero segment closes a packet on the last table byte
    push_header(8'h00, 64'h8000_0000_0000_0000, 32'h0, 32'h0, 8'd3, 1'b1);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd3);
    // two leading zeros, a one-byte segment with a trailing zero, then two bytes
    push_header(8'h02, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1234_5678, 32'h0000_0001, 8'd5, 1'b1);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h01, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h00, 1'b1, KIND_HEADER, 8'd0);
    push_row(8'h02, 1'b1, KIND_HEADER, 8'd2);
    push_row(8'h00, 1'b1, KIND_PAYLOAD, 8'd2);
    push_row(8'hFF, 1'b1, KIND_PAYLOAD, 8'd0);
    push_row(8'hA5, 1'b1, KIND_PAYLOAD, 8'd1);

    add_random_page(1'b1);
    while (stream_plan.size() < ITEM_GOAL) add_random_page(1'b0);

    // bad pattern or version stops the parser for good, so it goes last
    push_header(8'($urandom), {$urandom, $urandom}, $urandom, $urandom,
                8'($urandom_range(255)), 1'b0);
    bad_pos = stream_plan.size() - 27 + $urandom_range(4);
    stream_plan[bad_pos].b = stream_plan[bad_pos].b ^ (8'd1 << $urandom_range(7));
    for (int i = 0; i < 12; i++) push_row(8'($urandom_range(255)), 1'b0, KIND_HEADER, 8'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (!timed_out && (plan_idx < stream_plan.size() || pending_results.size() != 0)) begin
      @(negedge clk);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (!timed_out && mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ogg_pd_pkg.sv
sv/ogg_pd_seg_mem.sv
sv/ogg_pd_parser.sv
sv/ogg_page_deframer.sv
sim/tb_ogg_page_deframer.sv
